// ===== design/bounded_set_table_assert.svh =====
// Assertion macros used by the checker of bounded_set_table.
`ifndef BOUNDED_SET_TABLE_ASSERT_SVH
`define BOUNDED_SET_TABLE_ASSERT_SVH

// Checked only while out of reset.
`define BST_ASSERT_SYNC(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define BST_ASSERT_RAW(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/bst_pkg.sv =====
`default_nettype none

package bst_pkg;

    localparam int REQ_W   = 2;
    localparam int KEY_W   = 32;
    localparam int CAP_W   = 5;
    localparam int COUNT_W = 5;

    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic load;
        logic scan;
        logic start_shift;
        logic shift;
        logic append;
        logic drop;
        logic ok_set;
        logic ok_val;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic             scan_done;
        logic             found;
        logic [REQ_W-1:0] op;
        logic             room;
        logic             shift_needed;
        logic             shift_done;
    } sts_t;

endpackage

`default_nettype wire

// ===== design/bounded_set_table.sv =====
// A request is accepted in idle, its key compared against the n keys held until a match
// or the end of the set, then decided; a remove that is not of the last key compacts the
// keys above it first. The time taken is set by the scan and compaction of the key memory.
// Throughput: one request at a time; the next beat is taken once the result is registered,
// even if the result is not yet taken, and a new result waits until the last one is taken.
// Sync reset (aresetn low) empties the set, sets capacity 16, drops m_tvalid; no memory clear.
`default_nettype none

module bounded_set_table #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bst_pkg::KEY_W-1:0]     s_tdata,     // key
    input  wire logic [bst_pkg::REQ_W-1:0]     s_tuser,     // req_type
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,     // ok, count[4:0], zero pad
    input  wire logic                          cfg_wr_en,
    input  wire logic [bst_pkg::CAP_W-1:0]     cfg_wr_data  // capacity
);

    bst_pkg::cmd_t               cmd;
    bst_pkg::sts_t               sts;
    logic                        out_ok;
    logic [bst_pkg::COUNT_W-1:0] out_count;

    bst_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bst_datapath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_ok      (out_ok),
        .out_count   (out_count)
    );

    assign m_tdata = {2'b00, out_count, out_ok};

endmodule

`default_nettype wire

// ===== design/bst_datapath.sv =====
`default_nettype none

module bst_datapath #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [bst_pkg::KEY_W-1:0]    s_tdata,
    input  wire logic [bst_pkg::REQ_W-1:0]    s_tuser,
    input  wire logic                         cfg_wr_en,
    input  wire logic [bst_pkg::CAP_W-1:0]    cfg_wr_data,
    input  wire bst_pkg::cmd_t                cmd,
    output bst_pkg::sts_t                     sts,
    output logic                              out_ok,
    output logic [bst_pkg::COUNT_W-1:0]       out_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = $clog2(DEPTH + 1);
    localparam int CW = (IW > bst_pkg::COUNT_W) ? IW : bst_pkg::COUNT_W;
    localparam int KW = (KEY_WIDTH < bst_pkg::KEY_W) ? KEY_WIDTH : bst_pkg::KEY_W;

    logic [KW-1:0] mem [DEPTH];

    logic [KW-1:0]               key_reg, key_next;
    logic [bst_pkg::REQ_W-1:0]   op_reg, op_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic                        cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]               cmp_idx_reg, cmp_idx_next;
    logic                        found_reg, found_next;
    logic [IW-1:0]               pos_reg, pos_next;
    logic [IW-1:0]               used_reg, used_next;
    logic [bst_pkg::CAP_W-1:0]   cap_reg, cap_next;
    logic                        ok_reg, ok_next;
    logic                        out_ok_reg, out_ok_next;
    logic [bst_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [KW-1:0]               rd_data_reg;

    logic          hit;
    logic          issue;
    logic          scan_done;
    logic [IW-1:0] pos_inc;
    logic [IW-1:0] shift_dst;
    logic [CW-1:0] limit;
    logic [CW-1:0] used_ext;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_data;

    assign hit       = cmp_vld_reg && (rd_data_reg == key_reg);
    assign issue     = ((cmd.scan && !hit) || cmd.shift) && (idx_reg < used_reg);
    assign scan_done = hit || ((idx_reg == used_reg) && !cmp_vld_reg);
    assign pos_inc   = pos_reg + IW'(1);
    assign shift_dst = cmp_idx_reg - IW'(1);
    assign used_ext  = CW'(used_reg);
    assign limit     = (CW'(cap_reg) < CW'(DEPTH)) ? CW'(cap_reg) : CW'(DEPTH);

    always_comb begin
        key_next       = key_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        cmp_vld_next   = issue;
        cmp_idx_next   = idx_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        used_next      = used_reg;
        cap_next       = cap_reg;
        ok_next        = ok_reg;
        out_ok_next    = out_ok_reg;
        out_count_next = out_count_reg;
        wr_en          = 1'b0;
        wr_addr        = used_reg[AW-1:0];
        wr_data        = key_reg;

        if (cmd.load) begin
            key_next   = s_tdata[KW-1:0];
            op_next    = s_tuser;
            idx_next   = '0;
            found_next = 1'b0;
        end
        if (issue) begin
            idx_next = idx_reg + IW'(1);
        end
        if (cmd.scan && scan_done) begin
            found_next = hit;
            pos_next   = cmp_idx_reg;
        end
        if (cmd.start_shift) begin
            idx_next = pos_inc;
        end
        if (cmd.append) begin
            wr_en     = 1'b1;
            used_next = used_reg + IW'(1);
        end
        if (cmd.shift && cmp_vld_reg) begin
            wr_en   = 1'b1;
            wr_addr = shift_dst[AW-1:0];
            wr_data = rd_data_reg;
        end
        if (cmd.drop) begin
            used_next = used_reg - IW'(1);
        end
        if (cmd.ok_set) begin
            ok_next = cmd.ok_val;
        end
        if (cmd.out_load) begin
            out_ok_next    = ok_reg;
            out_count_next = used_ext[bst_pkg::COUNT_W-1:0];
        end
        if (cfg_wr_en) begin
            cap_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            cap_reg     <= bst_pkg::CAP_RESET;
            cmp_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            used_reg    <= used_next;
            cap_reg     <= cap_next;
            cmp_vld_reg <= cmp_vld_next;
            idx_reg     <= idx_next;
        end
        key_reg       <= key_next;
        op_reg        <= op_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        ok_reg        <= ok_next;
        out_ok_reg    <= out_ok_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    assign sts.scan_done    = scan_done;
    assign sts.found        = found_reg;
    assign sts.op           = op_reg;
    assign sts.room         = used_ext < limit;
    assign sts.shift_needed = pos_inc < used_reg;
    assign sts.shift_done   = (idx_reg == used_reg) && !cmp_vld_reg;

    assign out_ok    = out_ok_reg;
    assign out_count = out_count_reg;

endmodule

`default_nettype wire

// ===== design/bst_controller.sv =====
`default_nettype none

module bst_controller (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire bst_pkg::sts_t  sts,
    output bst_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        cmd           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.ok_set = 1'b1;
                state_next = ST_RESP;
                case (sts.op)
                    bst_pkg::REQ_QUERY: begin
                        cmd.ok_val = sts.found;
                    end
                    bst_pkg::REQ_ADD: begin
                        if (!sts.found && sts.room) begin
                            cmd.append = 1'b1;
                            cmd.ok_val = 1'b1;
                        end
                    end
                    bst_pkg::REQ_REMOVE: begin
                        if (sts.found) begin
                            if (sts.shift_needed) begin
                                cmd.ok_set      = 1'b0;
                                cmd.start_shift = 1'b1;
                                state_next      = ST_SHIFT;
                            end else begin
                                cmd.drop   = 1'b1;
                                cmd.ok_val = 1'b1;
                            end
                        end
                    end
                    default: begin
                        cmd.ok_val = 1'b0;
                    end
                endcase
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (sts.shift_done) begin
                    cmd.drop   = 1'b1;
                    cmd.ok_set = 1'b1;
                    cmd.ok_val = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ===== design/bst_checker.sv =====
`default_nettype none
`include "bounded_set_table_assert.svh"

module bst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    `BST_ASSERT_SYNC(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `BST_ASSERT_SYNC(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "new beat taken while request in progress")
    `BST_ASSERT_SYNC(a_pad_zero, m_tvalid |-> m_tdata[7:6] == 2'b00, "result pad bits not zero")
    `BST_ASSERT_RAW(a_reset_clears, !aresetn |=> !m_tvalid, "result valid survived reset")

endmodule

bind bounded_set_table bst_checker u_bst_checker (.*);

`default_nettype wire

// ===== tb/sv/set_table_checker.sv =====
`timescale 1ns / 1ps

module set_table_checker #(
    parameter int DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [bst_pkg::KEY_W-1:0]   s_tdata,     // key
    input  logic [bst_pkg::REQ_W-1:0]   s_tuser,     // req_type
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [7:0]                  m_tdata,     // ok, count[4:0], zero pad
    input  logic                        cfg_wr_en,
    input  logic [bst_pkg::CAP_W-1:0]   cfg_wr_data, // capacity
    output int                          mismatches,
    output int                          results_outstanding,
    output int                          results_checked
);

    typedef struct packed {
        logic                         ok;
        logic [bst_pkg::COUNT_W-1:0]  count;
    } set_result_t;

    logic [bst_pkg::KEY_W-1:0]  held_keys [DEPTH];
    int                         held;
    logic [bst_pkg::CAP_W-1:0]  capacity_q;
    set_result_t                results_due [$];
    set_result_t                want;
    set_result_t                got;

    initial begin
        mismatches          = 0;
        results_outstanding = 0;
        results_checked     = 0;
        held                = 0;
        capacity_q          = bst_pkg::CAP_RESET;
    end

    function automatic set_result_t apply_request(input logic [bst_pkg::REQ_W-1:0] op,
                                                  input logic [bst_pkg::KEY_W-1:0] key);
        int          pos;
        int          limit;
        int          i;
        logic        hit;
        set_result_t r;
        limit = (int'(capacity_q) < DEPTH) ? int'(capacity_q) : DEPTH;
        pos = held;
        for (i = held - 1; i >= 0; i--) begin
            if (held_keys[i] == key) pos = i;
        end
        hit = (pos < held);
        r.ok = 1'b0;
        case (op)
            bst_pkg::REQ_QUERY: begin
                r.ok = hit;
            end
            bst_pkg::REQ_ADD: begin
                if (!hit && held < limit) begin
                    held_keys[held] = key;
                    held++;
                    r.ok = 1'b1;
                end
            end
            bst_pkg::REQ_REMOVE: begin
                if (hit) begin
                    for (i = pos; i < held - 1; i++) held_keys[i] = held_keys[i + 1];
                    held--;
                    r.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count = held[bst_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held       = 0;
            capacity_q = bst_pkg::CAP_RESET;
            results_due.delete();
        end else begin
            if (cfg_wr_en) capacity_q = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got.ok    = m_tdata[0];
                got.count = m_tdata[5:1];
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result beat 0x%02h with nothing expected",
                                              m_tdata));
                end else begin
                    want = results_due.pop_front();
                    if (got.ok !== want.ok)
                        report_mismatch($sformatf("result %0d ok got %0b expected %0b",
                                                  results_checked, got.ok, want.ok));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("result %0d count got %0d expected %0d",
                                                  results_checked, got.count, want.count));
                end
                results_checked++;
            end
            if (s_tvalid && s_tready) results_due.push_back(apply_request(s_tuser, s_tdata));
        end
        results_outstanding <= results_due.size();
    end

endmodule

// ===== tb/sv/bounded_set_table_test.sv =====
`timescale 1ns / 1ps

module bounded_set_table_test;

    localparam int                        DEPTH          = 16;
    localparam int                        WATCHDOG_LIMIT = 5000;
    localparam int                        RANDOM_PHASES  = 9;
    localparam int                        PHASE_ITEMS    = 105;
    localparam int                        POOL_SIZE      = 24;
    localparam logic [bst_pkg::REQ_W-1:0] REQ_UNKNOWN    = 2'd3;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_tvalid    = 1'b0;
    logic                        s_tready;
    logic [bst_pkg::KEY_W-1:0]   s_tdata     = '0;
    logic [bst_pkg::REQ_W-1:0]   s_tuser     = '0;
    logic                        m_tvalid;
    logic                        m_tready    = 1'b0;
    logic [7:0]                  m_tdata;
    logic                        cfg_wr_en   = 1'b0;
    logic [bst_pkg::CAP_W-1:0]   cfg_wr_data = '0;

    int                          mismatches;
    int                          results_outstanding;
    int                          results_checked;
    int                          tx_idle_pct = 13;
    int                          rx_idle_pct = 82;
    logic                        hold_req    = 1'b0;
    int                          requests_sent = 0;
    int                          cap_settings  = 0;
    logic [bst_pkg::KEY_W-1:0]   key_pool [POOL_SIZE];

    always #6 aclk = ~aclk;

    bounded_set_table #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (bst_pkg::KEY_W)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    set_table_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .mismatches          (mismatches),
        .results_outstanding (results_outstanding),
        .results_checked     (results_checked)
    );

    // receiver: random backpressure plus one long hold-off on request
    initial begin : rx_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: %0d cycles without a beat", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_req(input logic [bst_pkg::REQ_W-1:0] op,
                            input logic [bst_pkg::KEY_W-1:0] key);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_outstanding != 0) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [bst_pkg::CAP_W-1:0] cap);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_settings++;
    endtask

    task automatic random_req;
        int                          pick;
        logic [bst_pkg::REQ_W-1:0]   op;
        logic [bst_pkg::KEY_W-1:0]   key;
        pick = $urandom_range(99);
        if (pick < 40)      op = bst_pkg::REQ_ADD;
        else if (pick < 70) op = bst_pkg::REQ_REMOVE;
        else if (pick < 95) op = bst_pkg::REQ_QUERY;
        else                op = REQ_UNKNOWN;
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else                         key = $urandom;
        send_req(op, key);
    endtask

    initial begin : stimulus
        logic [bst_pkg::CAP_W-1:0] phase_cap [RANDOM_PHASES];
        int                        p;
        int                        n;
        phase_cap = '{5'd3, 5'd16, 5'd31, 5'd1, 5'd0, 5'd9, 5'd16, 5'd2, 5'd16};
        phase_cap[RANDOM_PHASES - 1] = 5'($urandom_range(16, 1));
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (p = 2; p < POOL_SIZE; p++) key_pool[p] = $urandom;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every op, compaction, last-entry remove, capacity edges
        set_capacity(5'd16);
        send_req(bst_pkg::REQ_QUERY,  32'h0000_0000);
        send_req(bst_pkg::REQ_REMOVE, 32'h0000_0000);
        send_req(bst_pkg::REQ_ADD,    32'h0000_0000);
        send_req(bst_pkg::REQ_ADD,    32'hFFFF_FFFF);
        send_req(bst_pkg::REQ_ADD,    32'h0000_0000);
        send_req(bst_pkg::REQ_QUERY,  32'hFFFF_FFFF);
        send_req(REQ_UNKNOWN,         32'hFFFF_FFFF);
        send_req(bst_pkg::REQ_ADD,    32'hA5A5_A5A5);
        send_req(bst_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
        send_req(bst_pkg::REQ_QUERY,  32'hA5A5_A5A5);
        send_req(bst_pkg::REQ_REMOVE, 32'hA5A5_A5A5);
        send_req(bst_pkg::REQ_REMOVE, 32'h0000_0000);
        set_capacity(5'd2);
        send_req(bst_pkg::REQ_ADD,    32'h0000_0001);
        send_req(bst_pkg::REQ_ADD,    32'h0000_0002);
        send_req(bst_pkg::REQ_ADD,    32'h0000_0003);
        set_capacity(5'd1);
        send_req(bst_pkg::REQ_ADD,    32'h0000_0003);
        send_req(bst_pkg::REQ_REMOVE, 32'h0000_0001);
        send_req(bst_pkg::REQ_ADD,    32'h0000_0003);
        send_req(bst_pkg::REQ_REMOVE, 32'h0000_0002);
        send_req(bst_pkg::REQ_ADD,    32'h0000_0003);
        set_capacity(5'd0);
        send_req(bst_pkg::REQ_ADD,    32'h0000_0004);
        send_req(bst_pkg::REQ_QUERY,  32'h0000_0003);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            set_capacity(phase_cap[p]);
            if (p == 3) begin
                tx_idle_pct <= 82;
                rx_idle_pct <= 13;
            end else if (p == 6) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 6 && n == 10) hold_req <= 1'b1;
                random_req();
            end
        end

        drain();
        repeat (DEPTH + 8) @(posedge aclk);

        $display("Summary: %0d requests, %0d results checked, %0d capacity settings",
                 requests_sent, results_checked, cap_settings);
        $display("Summary: sender/receiver idle 13/82, 82/13 and 0/0, one long receiver hold");
        if (mismatches == 0 && results_outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
